// ===== rtl/rsrm_pkg.sv =====
// Receive slot ring manager: shared types, codes and field widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rsrm_pkg;

  localparam int ADDR_W    = 48;
  localparam int OFF_W     = 20;
  localparam int IDX_OUT_W = 5;
  localparam int POS_W     = 6;
  localparam int N_W       = 8;
  localparam int CNT_W     = 3;
  localparam int SIZE_W    = 4;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 5;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_FETCH    = 2'd2,
    OP_ACK      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_OFF  = 2'd3
  } status_t;

  localparam logic [1:0] REG_SLOT_COUNT  = 2'd0;
  localparam logic [1:0] REG_SLOT_SIZE   = 2'd1;
  localparam logic [1:0] REG_BUFFER_BASE = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]  slot_count_log2;
    logic [SIZE_W-1:0] slot_size_log2;
    logic [ADDR_W-1:0] buffer_base;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/rsrm_cfg_regs.sv =====
// Receive slot ring manager: APB-style configuration registers.
// Depends on rsrm_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none
module rsrm_cfg_regs
  import rsrm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[PADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SLOT_COUNT:  cfg_nxt.slot_count_log2 = pwdata[CNT_W-1:0];
        REG_SLOT_SIZE:   cfg_nxt.slot_size_log2  = pwdata[SIZE_W-1:0];
        REG_BUFFER_BASE: cfg_nxt.buffer_base     = pwdata[ADDR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SLOT_COUNT:  prdata = PDATA_W'(cfg_r.slot_count_log2);
      REG_SLOT_SIZE:   prdata = PDATA_W'(cfg_r.slot_size_log2);
      REG_BUFFER_BASE: prdata = PDATA_W'(cfg_r.buffer_base);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsrm_ctrl.sv =====
// Receive slot ring manager: two-state controller sequencing load and commit.
// Depends on rsrm_pkg for the command and status bundles.
`timescale 1ns / 1ps
`default_nettype none
module rsrm_ctrl
  import rsrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid & in_ready;
  assign cmd.commit = (state_r == S_EXEC) & stat.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsrm_dpath.sv =====
// Receive slot ring manager: masks, positions, round-robin search and result word.
// Depends on rsrm_pkg; driven by rsrm_ctrl commands and rsrm_cfg_regs settings.
`timescale 1ns / 1ps
`default_nettype none
module rsrm_dpath
  import rsrm_pkg::*;
#(
  parameter int MAX_SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_location,
  input  wire logic              in_success,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [IDX_OUT_W-1:0]   out_slot_index,
  output logic [OFF_W-1:0]       out_message_offset,
  output logic                   out_was_unread
);

  localparam int IDXW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // held item
  op_t               op_r;
  logic              succ_r;
  logic [ADDR_W-1:0] diff_r;

  // ring state
  logic [MAX_SLOTS-1:0] occ_r, occ_nxt;
  logic [MAX_SLOTS-1:0] unr_r, unr_nxt;
  logic [POS_W-1:0]     wpos_r, wpos_nxt;
  logic [POS_W-1:0]     rpos_r, rpos_nxt;

  // result word
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [IDX_OUT_W-1:0] idx_r, idx_nxt;
  logic [OFF_W-1:0]     moff_r, moff_nxt;
  logic                 was_r, was_nxt;

  logic [N_W-1:0]       pow_n;
  logic [N_W-1:0]       n_slots;
  logic [MAX_SLOTS-1:0] vmask;
  logic [MAX_SLOTS-1:0] cand;
  logic [MAX_SLOTS-1:0] ge_start;
  logic [MAX_SLOTS-1:0] cand_hi;
  logic [POS_W-1:0]     pos_sel;
  logic [IDXW-1:0]      start;
  logic [IDXW-1:0]      hi_idx, lo_idx, hit_idx;
  logic                 found;
  logic [ADDR_W-1:0]    shifted;
  logic                 in_range;
  logic [IDXW-1:0]      raw_idx;
  logic [POS_W-1:0]     hit_pos, raw_pos;

  assign stat.out_free = ~out_valid_r | out_ready;

  // slots in use, capped at the ring size
  always_comb begin
    pow_n   = N_W'(1) << cfg.slot_count_log2;
    n_slots = (pow_n > N_W'(MAX_SLOTS)) ? N_W'(MAX_SLOTS) : pow_n;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      vmask[j] = N_W'(j) < n_slots;
    end
  end

  // round-robin search, shared by alloc and fetch
  always_comb begin
    if (op_r == OP_ALLOC) begin
      cand    = ~occ_r & vmask;
      pos_sel = wpos_r;
    end else begin
      cand    = unr_r & vmask;
      pos_sel = rpos_r;
    end
    start = ({2'b00, pos_sel} < n_slots) ? pos_sel[IDXW-1:0] : '0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      ge_start[j] = (IDXW + 1)'(j) >= {1'b0, start};
    end
    cand_hi = cand & ge_start;
    hi_idx  = '0;
    lo_idx  = '0;
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (cand_hi[j]) hi_idx = IDXW'(j);
      if (cand[j])    lo_idx = IDXW'(j);
    end
    found   = |cand;
    hit_idx = (|cand_hi) ? hi_idx : lo_idx;
    hit_pos = POS_W'(hit_idx);
  end

  // address to slot mapping with bounds check
  always_comb begin
    shifted  = diff_r >> cfg.slot_size_log2;
    in_range = (shifted[ADDR_W-1:N_W] == '0) && (shifted[N_W-1:0] < n_slots);
    raw_idx  = shifted[IDXW-1:0];
    raw_pos  = POS_W'(raw_idx);
  end

  always_comb begin
    occ_nxt    = occ_r;
    unr_nxt    = unr_r;
    wpos_nxt   = wpos_r;
    rpos_nxt   = rpos_r;
    status_nxt = ST_OK;
    idx_nxt    = '0;
    moff_nxt   = '0;
    was_nxt    = 1'b0;
    unique case (op_r)
      OP_ALLOC: begin
        if (found) begin
          occ_nxt[hit_idx] = 1'b1;
          wpos_nxt         = hit_pos + POS_W'(1);
          idx_nxt          = hit_pos[IDX_OUT_W-1:0];
        end else begin
          status_nxt = ST_NO_SPACE;
        end
      end
      OP_COMPLETE: begin
        if (in_range) begin
          if (succ_r) unr_nxt[raw_idx] = 1'b1;
          else        occ_nxt[raw_idx] = 1'b0;
          idx_nxt = raw_pos[IDX_OUT_W-1:0];
        end else begin
          status_nxt = ST_BAD_OFF;
        end
      end
      OP_FETCH: begin
        if (found) begin
          unr_nxt[hit_idx] = 1'b0;
          rpos_nxt         = hit_pos + POS_W'(1);
          idx_nxt          = hit_pos[IDX_OUT_W-1:0];
          moff_nxt         = OFF_W'(hit_pos) << cfg.slot_size_log2;
        end else begin
          status_nxt = ST_EMPTY;
          moff_nxt   = '1;
        end
      end
      OP_ACK: begin
        if (in_range) begin
          occ_nxt[raw_idx] = 1'b0;
          unr_nxt[raw_idx] = 1'b0;
          was_nxt          = unr_r[raw_idx];
          idx_nxt          = raw_pos[IDX_OUT_W-1:0];
        end else begin
          status_nxt = ST_BAD_OFF;
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_opcode);
      succ_r <= in_success;
      diff_r <= (op_t'(in_opcode) == OP_COMPLETE) ? (in_location - cfg.buffer_base)
                                                  : in_location;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      moff_r   <= moff_nxt;
      was_r    <= was_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      unr_r       <= '0;
      wpos_r      <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        occ_r       <= occ_nxt;
        unr_r       <= unr_nxt;
        wpos_r      <= wpos_nxt;
        rpos_r      <= rpos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_index     = idx_r;
  assign out_message_offset = moff_r;
  assign out_was_unread     = was_r;

endmodule
`default_nettype wire

// ===== rtl/receive_slot_ring_manager.sv =====
// Receive slot ring manager top level: config registers, controller, datapath.
// Depends on rsrm_pkg, rsrm_cfg_regs, rsrm_ctrl and rsrm_dpath.
//
//   channel  handshake          payload
//   in       in_valid/in_ready  in_opcode, in_location, in_success
//   out      out_valid/out_ready out_status, out_slot_index, out_message_offset,
//                                out_was_unread
//   cfg      psel/penable/pwrite paddr, pwdata, prdata, pready (always high)
//
// Each word is taken in (address offset subtract for completions), then the
// round-robin search or slot mapping and the mask update are committed.
// The result register frees the input side; a stalled result holds the
// commit step until out_ready. Reset clears masks, positions, config, out_valid.
`timescale 1ns / 1ps
`default_nettype none
module receive_slot_ring_manager
  import rsrm_pkg::*;
#(
  parameter int MAX_SLOTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ADDR_W-1:0]  in_location,
  input  wire logic               in_success,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [IDX_OUT_W-1:0]    out_slot_index,
  output logic [OFF_W-1:0]        out_message_offset,
  output logic                    out_was_unread,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  rsrm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsrm_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_location        (in_location),
    .in_success         (in_success),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_message_offset (out_message_offset),
    .out_was_unread     (out_was_unread)
  );

endmodule
`default_nettype wire
